@@ rtl/fca_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_pkg
// Shared constants, codes and types of the allocation table engine.
// ----------------------------------------------------------------------------
package fca_pkg;

   localparam int BLOCKS     = 64;
   localparam int ADDR_W     = $clog2(BLOCKS);
   localparam int ENTRY_W    = 7;
   localparam int COUNT_W    = 7;

   localparam logic [ENTRY_W-1:0] END_MARK  = ENTRY_W'(BLOCKS);
   localparam logic [ENTRY_W-1:0] FREE_MARK = ENTRY_W'(BLOCKS + 1);

   typedef enum logic [2:0] {
      FUNC_ALLOC      = 3'd0,
      FUNC_ALLOC_CHAIN = 3'd1,
      FUNC_FREE_CHAIN = 3'd2,
      FUNC_SET_NEXT   = 3'd3,
      FUNC_GET_NEXT   = 3'd4,
      FUNC_IS_USED    = 3'd5,
      FUNC_LIST_CHAIN = 3'd6,
      FUNC_CLEAR      = 3'd7
   } func_type;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_FREE = 2'd1;
   localparam logic [1:0] ST_RANGE   = 2'd2;
   localparam logic [1:0] ST_CYCLE   = 2'd3;

   typedef struct packed {
      logic               en;
      logic [ADDR_W-1:0]  addr;
      logic [ENTRY_W-1:0] data;
   } tbl_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } tbl_rd_type;

endpackage

@@ rtl/fat_chain_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_allocator_core
// Allocation table engine: alloc, chain alloc, free, set/get/test, list, clear.
// steps: reject/clear go straight to the reply; set/get/test read the entry
// and reply; scans and walks read each entry visited through the registered
// table read port, alloc marks each block it takes; one operation at a time
// reset: every entry reads FREE, used count 0, block_count 64, no response
// ----------------------------------------------------------------------------
module fat_chain_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,  // func, block, next_value, count
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,  // status, valid_block, block_out, entry_value,
                                   // is_used, used_count, free_count
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data    // block_count
);

   typedef enum logic [6:0] {
      S_IDLE      = 7'b0000001,
      S_RD        = 7'b0000010,
      S_SCAN_CHK  = 7'b0000100,
      S_MARK      = 7'b0001000,
      S_WALK_CHK  = 7'b0010000,
      S_ENTRY_CHK = 7'b0100000,
      S_REPLY     = 7'b1000000
   } state_type;

   state_type                          state_ff, state_in;
   fca_pkg::func_type                  func_ff, func_in;
   logic [fca_pkg::ENTRY_W-1:0]        nv_ff, nv_in;
   logic [fca_pkg::COUNT_W-1:0]        cnt_ff, cnt_in, n_ff, n_in;
   logic [fca_pkg::COUNT_W-1:0]        bc_ff, bc_in, used_ff, used_in;
   logic [fca_pkg::ADDR_W-1:0]         idx_ff, idx_in, prev_ff, prev_in;
   logic [1:0]                         st_ff, st_in;

   logic                               rsp_valid_ff;
   logic [31:0]                        rsp_data_ff;
   logic                               rsp_last_ff;

   fca_pkg::tbl_wr_type                wr;
   fca_pkg::tbl_rd_type                rd;
   logic                               tbl_clear;
   logic [fca_pkg::ENTRY_W-1:0]        v;

   logic                               emit, e_vb, e_isu, e_last;
   logic [1:0]                         e_st;
   logic [fca_pkg::ADDR_W-1:0]         e_blk;
   logic [fca_pkg::ENTRY_W-1:0]        e_ev;
   logic [fca_pkg::COUNT_W-1:0]        e_used, e_free, free_now;
   logic                               slot_free;
   logic                               w_fin, w_bad, w_cyc, w_last;
   logic [1:0]                         w_st;
   logic [fca_pkg::ENTRY_W-1:0]        r_blk;
   logic [fca_pkg::COUNT_W-1:0]        r_cnt;
   fca_pkg::func_type                  r_func;

   fca_table u_table (
      .clock   (clock),
      .reset   (reset),
      .clear   (tbl_clear),
      .wr      (wr),
      .rd      (rd),
      .rd_data (v)
   );

   assign r_func    = fca_pkg::func_type'(req_tdata[2:0]);
   assign r_blk     = req_tdata[9:3];
   assign r_cnt     = req_tdata[23:17];
   assign slot_free = !rsp_valid_ff || rsp_tready;
   assign free_now  = bc_ff - used_ff;

   assign csr_ready  = (state_ff == S_IDLE);
   assign req_tready = (state_ff == S_IDLE) && !csr_valid;

   // walk step outcome
   assign w_fin  = (v == fca_pkg::END_MARK) || (v == fca_pkg::FREE_MARK);
   assign w_bad  = !w_fin && (v >= bc_ff);
   assign w_cyc  = !w_fin && !w_bad && ((n_ff + 7'd1) == bc_ff);
   assign w_last = w_fin || w_bad || w_cyc;
   assign w_st   = w_bad ? fca_pkg::ST_RANGE : (w_cyc ? fca_pkg::ST_CYCLE : fca_pkg::ST_OK);

   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      nv_in     = nv_ff;
      cnt_in    = cnt_ff;
      n_in      = n_ff;
      bc_in     = bc_ff;
      used_in   = used_ff;
      idx_in    = idx_ff;
      prev_in   = prev_ff;
      st_in     = st_ff;
      tbl_clear = 1'b0;
      wr        = '0;
      rd.en     = 1'b0;
      rd.addr   = idx_ff;
      emit      = 1'b0;
      e_st      = fca_pkg::ST_OK;
      e_vb      = 1'b0;
      e_blk     = '0;
      e_ev      = '0;
      e_isu     = 1'b0;
      e_used    = used_ff;
      e_last    = 1'b1;

      case (state_ff)
         S_IDLE: begin
            if (csr_valid) begin
               if (csr_data == 7'd0) begin
                  bc_in = 7'd1;
               end else if (csr_data > 7'(fca_pkg::BLOCKS)) begin
                  bc_in = 7'(fca_pkg::BLOCKS);
               end else begin
                  bc_in = csr_data;
               end
               tbl_clear = 1'b1;
               used_in   = '0;
            end else if (req_tvalid) begin
               func_in = r_func;
               nv_in   = req_tdata[16:10];
               cnt_in  = r_cnt;
               n_in    = '0;
               idx_in  = '0;
               st_in   = fca_pkg::ST_OK;
               case (r_func)
                  fca_pkg::FUNC_ALLOC: begin
                     cnt_in = 7'd1;
                     if (free_now == 7'd0) begin
                        st_in    = fca_pkg::ST_NO_FREE;
                        state_in = S_REPLY;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  fca_pkg::FUNC_ALLOC_CHAIN: begin
                     if (r_cnt == 7'd0) begin
                        state_in = S_REPLY;
                     end else if (r_cnt > free_now) begin
                        st_in    = fca_pkg::ST_NO_FREE;
                        state_in = S_REPLY;
                     end else begin
                        state_in = S_RD;
                     end
                  end
                  fca_pkg::FUNC_FREE_CHAIN, fca_pkg::FUNC_LIST_CHAIN: begin
                     if (r_blk == fca_pkg::END_MARK || r_blk == fca_pkg::FREE_MARK) begin
                        state_in = S_REPLY;
                     end else if (r_blk >= bc_ff) begin
                        st_in    = fca_pkg::ST_RANGE;
                        state_in = S_REPLY;
                     end else begin
                        idx_in   = r_blk[fca_pkg::ADDR_W-1:0];
                        state_in = S_RD;
                     end
                  end
                  fca_pkg::FUNC_SET_NEXT, fca_pkg::FUNC_GET_NEXT, fca_pkg::FUNC_IS_USED: begin
                     if (r_blk >= bc_ff) begin
                        st_in    = fca_pkg::ST_RANGE;
                        state_in = S_REPLY;
                     end else begin
                        idx_in   = r_blk[fca_pkg::ADDR_W-1:0];
                        state_in = S_RD;
                     end
                  end
                  default: begin
                     tbl_clear = 1'b1;
                     used_in   = '0;
                     state_in  = S_REPLY;
                  end
               endcase
            end
         end

         S_RD: begin
            rd.en = 1'b1;
            case (func_ff)
               fca_pkg::FUNC_ALLOC, fca_pkg::FUNC_ALLOC_CHAIN: state_in = S_SCAN_CHK;
               fca_pkg::FUNC_FREE_CHAIN, fca_pkg::FUNC_LIST_CHAIN: state_in = S_WALK_CHK;
               default: state_in = S_ENTRY_CHK;
            endcase
         end

         S_SCAN_CHK: begin
            if (v == fca_pkg::FREE_MARK) begin
               if (n_ff != 7'd0) begin
                  wr.en   = 1'b1;
                  wr.addr = prev_ff;
                  wr.data = {1'b0, idx_ff};
               end
               state_in = S_MARK;
            end else begin
               idx_in   = idx_ff + 6'd1;
               state_in = S_RD;
            end
         end

         S_MARK: begin
            if (slot_free) begin
               wr.en   = 1'b1;
               wr.addr = idx_ff;
               wr.data = fca_pkg::END_MARK;
               used_in = used_ff + 7'd1;
               emit    = 1'b1;
               e_vb    = 1'b1;
               e_blk   = idx_ff;
               e_used  = used_ff + 7'd1;
               e_last  = (n_ff + 7'd1) == cnt_ff;
               n_in    = n_ff + 7'd1;
               prev_in = idx_ff;
               if ((n_ff + 7'd1) == cnt_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_ff + 6'd1;
                  state_in = S_RD;
               end
            end
         end

         S_WALK_CHK: begin
            if (func_ff == fca_pkg::FUNC_FREE_CHAIN) begin
               wr.en   = 1'b1;
               wr.addr = idx_ff;
               wr.data = fca_pkg::FREE_MARK;
               if (v != fca_pkg::FREE_MARK) begin
                  used_in = used_ff - 7'd1;
               end
               if (w_last) begin
                  st_in    = w_st;
                  state_in = S_REPLY;
               end else begin
                  idx_in   = v[fca_pkg::ADDR_W-1:0];
                  n_in     = n_ff + 7'd1;
                  state_in = S_RD;
               end
            end else if (slot_free) begin
               emit   = 1'b1;
               e_st   = w_st;
               e_vb   = 1'b1;
               e_blk  = idx_ff;
               e_last = w_last;
               if (w_last) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = v[fca_pkg::ADDR_W-1:0];
                  n_in     = n_ff + 7'd1;
                  state_in = S_RD;
               end
            end
         end

         S_ENTRY_CHK: begin
            if (slot_free) begin
               emit     = 1'b1;
               e_vb     = 1'b1;
               e_blk    = idx_ff;
               state_in = S_IDLE;
               case (func_ff)
                  fca_pkg::FUNC_SET_NEXT: begin
                     wr.en   = 1'b1;
                     wr.addr = idx_ff;
                     wr.data = nv_ff;
                     if (v == fca_pkg::FREE_MARK && nv_ff != fca_pkg::FREE_MARK) begin
                        used_in = used_ff + 7'd1;
                     end else if (v != fca_pkg::FREE_MARK && nv_ff == fca_pkg::FREE_MARK) begin
                        used_in = used_ff - 7'd1;
                     end
                     e_used = used_in;
                  end
                  fca_pkg::FUNC_GET_NEXT: begin
                     e_ev  = v;
                     e_isu = (v != fca_pkg::FREE_MARK);
                  end
                  default: begin
                     e_isu = (v != fca_pkg::FREE_MARK);
                  end
               endcase
            end
         end

         S_REPLY: begin
            if (slot_free) begin
               emit     = 1'b1;
               e_st     = st_ff;
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign e_free = bc_ff - e_used;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         bc_ff        <= 7'(fca_pkg::BLOCKS);
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         bc_ff    <= bc_in;
         used_ff  <= used_in;
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      func_ff <= func_in;
      nv_ff   <= nv_in;
      cnt_ff  <= cnt_in;
      n_ff    <= n_in;
      idx_ff  <= idx_in;
      prev_ff <= prev_in;
      st_ff   <= st_in;
      if (emit) begin
         rsp_data_ff <= {1'b0, e_free, e_used, e_isu, e_ev, e_blk, e_vb, e_st};
         rsp_last_ff <= e_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

@@ rtl/fca_table.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fca_table
// Entry table: one write and one registered read port, per-entry valid bits
// so that an entry never written since reset or clear reads as FREE.
// ----------------------------------------------------------------------------
module fca_table (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  fca_pkg::tbl_wr_type          wr,
   input  fca_pkg::tbl_rd_type          rd,
   output logic [fca_pkg::ENTRY_W-1:0]  rd_data
);

   logic [fca_pkg::ENTRY_W-1:0] mem [fca_pkg::BLOCKS];
   logic [fca_pkg::BLOCKS-1:0]  valid_ff;
   logic [fca_pkg::ENTRY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff <= '0;
      end else if (wr.en) begin
         valid_ff[wr.addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data_ff <= valid_ff[rd.addr] ? mem[rd.addr] : fca_pkg::FREE_MARK;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the allocation table engine: directed operations
// cover every function and error path, then random phases with varied table
// sizes and idle patterns are checked against an in-bench table predictor.
// ----------------------------------------------------------------------------
module tb;

   typedef struct packed {
      logic [1:0] status;
      logic       valid_block;
      logic [5:0] block_out;
      logic [6:0] entry_value;
      logic       is_used;
      logic [6:0] used_count;
      logic [6:0] free_count;
      logic       last;
   } rsp_item_type;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int SETTLE      = 3 * fca_pkg::BLOCKS + 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [6:0]  csr_data = '0;

   // predictor state
   logic [fca_pkg::ENTRY_W-1:0] entry_model [fca_pkg::BLOCKS];
   int                          used_blocks;
   int                          table_size;
   rsp_item_type                pending_rsp [$];
   int                          chain_heads [$];

   int idle_pct  = 0;
   int stall_pct = 0;
   int err_count = 0;
   int rsp_count = 0;
   int op_count  = 0;
   int cycles    = 0;

   fat_chain_allocator_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // response checker
   always @(posedge clock) begin
      rsp_item_type got;
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[1:0], rsp_tdata[2], rsp_tdata[8:3], rsp_tdata[15:9],
                rsp_tdata[16], rsp_tdata[23:17], rsp_tdata[30:24], rsp_tlast};
         rsp_count++;
         if (pending_rsp.size() == 0) begin
            err_count++;
            if (err_count <= 10)
               $display("unexpected transaction: st=%0d vb=%0d blk=%0d last=%0d",
                        got.status, got.valid_block, got.block_out, got.last);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want || rsp_tdata[31] !== 1'b0) begin
               err_count++;
               if (err_count <= 10)
                  $display({"mismatch: exp st=%0d vb=%0d blk=%0d ev=%0d iu=%0d ",
                            "used=%0d free=%0d last=%0d | got st=%0d vb=%0d ",
                            "blk=%0d ev=%0d iu=%0d used=%0d free=%0d last=%0d"},
                           want.status, want.valid_block, want.block_out,
                           want.entry_value, want.is_used, want.used_count,
                           want.free_count, want.last, got.status,
                           got.valid_block, got.block_out, got.entry_value,
                           got.is_used, got.used_count, got.free_count, got.last);
            end
         end
      end
   end

   function automatic void add_rsp(logic [1:0] st, logic vb, int blk,
                                   logic [6:0] ev, logic iu, logic lst);
      rsp_item_type r;
      r.status      = st;
      r.valid_block = vb;
      r.block_out   = vb ? blk[5:0] : 6'd0;
      r.entry_value = ev;
      r.is_used     = iu;
      r.used_count  = 7'(used_blocks);
      r.free_count  = 7'(table_size - used_blocks);
      r.last        = lst;
      pending_rsp   = {pending_rsp, r};
   endfunction

   function automatic void wipe_table();
      entry_model = '{default: fca_pkg::FREE_MARK};
      used_blocks = 0;
      chain_heads.delete();
   endfunction

   function automatic void predict_op(fca_pkg::func_type f, logic [6:0] blk,
                                      logic [6:0] nv, logic [6:0] cnt);
      int         n;
      int         prev;
      int         cur;
      logic [6:0] v;
      logic [1:0] st;
      bit         done;
      case (f)
         fca_pkg::FUNC_ALLOC: begin
            done = 0;
            for (int i = 0; i < table_size && !done; i++) begin
               if (entry_model[i[fca_pkg::ADDR_W-1:0]] == fca_pkg::FREE_MARK) begin
                  entry_model[i[fca_pkg::ADDR_W-1:0]] = fca_pkg::END_MARK;
                  used_blocks++;
                  add_rsp(fca_pkg::ST_OK, 1, i, 0, 0, 1);
                  done = 1;
               end
            end
            if (!done)
               add_rsp(fca_pkg::ST_NO_FREE, 0, 0, 0, 0, 1);
         end
         fca_pkg::FUNC_ALLOC_CHAIN: begin
            if (cnt == 0) begin
               add_rsp(fca_pkg::ST_OK, 0, 0, 0, 0, 1);
            end else if (cnt > table_size - used_blocks) begin
               add_rsp(fca_pkg::ST_NO_FREE, 0, 0, 0, 0, 1);
            end else begin
               n = 0;
               prev = 0;
               for (int i = 0; i < table_size && n < cnt; i++) begin
                  if (entry_model[i[fca_pkg::ADDR_W-1:0]] == fca_pkg::FREE_MARK) begin
                     if (n > 0)
                        entry_model[prev[fca_pkg::ADDR_W-1:0]] = 7'(i);
                     else
                        chain_heads = {chain_heads, i};
                     entry_model[i[fca_pkg::ADDR_W-1:0]] = fca_pkg::END_MARK;
                     used_blocks++;
                     n++;
                     add_rsp(fca_pkg::ST_OK, 1, i, 0, 0, n == cnt);
                     prev = i;
                  end
               end
            end
         end
         fca_pkg::FUNC_FREE_CHAIN, fca_pkg::FUNC_LIST_CHAIN: begin
            st = fca_pkg::ST_OK;
            n = 0;
            done = 1;
            cur = blk;
            if (blk != fca_pkg::END_MARK && blk != fca_pkg::FREE_MARK) begin
               if (blk >= table_size) begin
                  st = fca_pkg::ST_RANGE;
               end else begin
                  done = 0;
                  while (n < table_size && !done) begin
                     v = entry_model[cur[fca_pkg::ADDR_W-1:0]];
                     if (f == fca_pkg::FUNC_FREE_CHAIN) begin
                        entry_model[cur[fca_pkg::ADDR_W-1:0]] = fca_pkg::FREE_MARK;
                        if (v != fca_pkg::FREE_MARK)
                           used_blocks--;
                     end else begin
                        add_rsp(fca_pkg::ST_OK, 1, cur, 0, 0, 0);
                     end
                     n++;
                     if (v == fca_pkg::END_MARK || v == fca_pkg::FREE_MARK) begin
                        done = 1;
                     end else if (v >= table_size) begin
                        st = fca_pkg::ST_RANGE;
                        done = 1;
                     end else begin
                        cur = v;
                     end
                  end
                  if (!done)
                     st = fca_pkg::ST_CYCLE;
               end
            end
            if (f == fca_pkg::FUNC_FREE_CHAIN || n == 0) begin
               add_rsp(st, 0, 0, 0, 0, 1);
            end else begin
               pending_rsp[pending_rsp.size()-1].status     = st;
               pending_rsp[pending_rsp.size()-1].used_count = 7'(used_blocks);
               pending_rsp[pending_rsp.size()-1].free_count =
                  7'(table_size - used_blocks);
               pending_rsp[pending_rsp.size()-1].last       = 1'b1;
            end
         end
         fca_pkg::FUNC_SET_NEXT: begin
            if (blk >= table_size) begin
               add_rsp(fca_pkg::ST_RANGE, 0, 0, 0, 0, 1);
            end else begin
               v = entry_model[blk[fca_pkg::ADDR_W-1:0]];
               if (v == fca_pkg::FREE_MARK && nv != fca_pkg::FREE_MARK)
                  used_blocks++;
               else if (v != fca_pkg::FREE_MARK && nv == fca_pkg::FREE_MARK)
                  used_blocks--;
               entry_model[blk[fca_pkg::ADDR_W-1:0]] = nv;
               add_rsp(fca_pkg::ST_OK, 1, blk, 0, 0, 1);
            end
         end
         fca_pkg::FUNC_GET_NEXT, fca_pkg::FUNC_IS_USED: begin
            if (blk >= table_size) begin
               add_rsp(fca_pkg::ST_RANGE, 0, 0, 0, 0, 1);
            end else begin
               v = entry_model[blk[fca_pkg::ADDR_W-1:0]];
               add_rsp(fca_pkg::ST_OK, 1, blk, (f == fca_pkg::FUNC_GET_NEXT) ? v : 7'd0,
                       v != fca_pkg::FREE_MARK, 1);
            end
         end
         default: begin
            wipe_table();
            add_rsp(fca_pkg::ST_OK, 0, 0, 0, 0, 1);
         end
      endcase
   endfunction

   // one request transaction; starts and ends at a falling edge
   task automatic send_op(fca_pkg::func_type f, logic [6:0] blk, logic [6:0] nv,
                          logic [6:0] cnt);
      while ($urandom_range(99) < idle_pct)
         @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {cnt, nv, blk, f};
      do @(posedge clock); while (!req_tready);
      predict_op(f, blk, nv, cnt);
      op_count++;
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   task automatic drain();
      while (pending_rsp.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_size(logic [6:0] value);
      drain();
      repeat (SETTLE) @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      table_size = (value < 1) ? 1 : (value > fca_pkg::BLOCKS) ? fca_pkg::BLOCKS : value;
      wipe_table();
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_directed_ops();
      send_op(fca_pkg::FUNC_ALLOC, 0, 0, 0);
      send_op(fca_pkg::FUNC_ALLOC_CHAIN, 0, 0, 0);
      send_op(fca_pkg::FUNC_ALLOC_CHAIN, 0, 0, 3);
      send_op(fca_pkg::FUNC_LIST_CHAIN, 1, 0, 0);
      send_op(fca_pkg::FUNC_SET_NEXT, 3, 1, 0);
      send_op(fca_pkg::FUNC_LIST_CHAIN, 1, 0, 0);
      send_op(fca_pkg::FUNC_FREE_CHAIN, 2, 0, 0);
      send_op(fca_pkg::FUNC_GET_NEXT, 70, 0, 0);
      send_op(fca_pkg::FUNC_IS_USED, 63, 0, 0);
      send_op(fca_pkg::FUNC_SET_NEXT, 5, 100, 0);
      send_op(fca_pkg::FUNC_LIST_CHAIN, 5, 0, 0);
      send_op(fca_pkg::FUNC_FREE_CHAIN, 5, 0, 0);
      send_op(fca_pkg::FUNC_LIST_CHAIN, fca_pkg::END_MARK, 0, 0);
      send_op(fca_pkg::FUNC_FREE_CHAIN, fca_pkg::FREE_MARK, 0, 0);
      send_op(fca_pkg::FUNC_LIST_CHAIN, 80, 0, 0);
      send_op(fca_pkg::FUNC_ALLOC_CHAIN, 0, 0, 64);
      send_op(fca_pkg::FUNC_CLEAR, 0, 0, 0);
      send_op(fca_pkg::FUNC_ALLOC_CHAIN, 127, 127, 64);
      send_op(fca_pkg::FUNC_ALLOC, 0, 0, 0);
      send_op(fca_pkg::FUNC_SET_NEXT, 63, fca_pkg::FREE_MARK, 0);
      send_op(fca_pkg::FUNC_GET_NEXT, 63, 0, 0);
      send_op(fca_pkg::FUNC_GET_NEXT, 127, 0, 0);
      send_op(fca_pkg::FUNC_LIST_CHAIN, 0, 0, 0);
      send_op(fca_pkg::FUNC_FREE_CHAIN, 0, 0, 0);
      send_op(fca_pkg::FUNC_ALLOC_CHAIN, 0, 0, 127);
   endtask

   task automatic test_size_extremes();
      write_size(7'd0);
      send_op(fca_pkg::FUNC_ALLOC, 0, 0, 0);
      send_op(fca_pkg::FUNC_ALLOC, 0, 0, 0);
      send_op(fca_pkg::FUNC_LIST_CHAIN, 0, 0, 0);
      send_op(fca_pkg::FUNC_SET_NEXT, 1, 0, 0);
      send_op(fca_pkg::FUNC_SET_NEXT, 0, 0, 0);
      send_op(fca_pkg::FUNC_LIST_CHAIN, 0, 0, 0);
      write_size(7'd127);
      send_op(fca_pkg::FUNC_ALLOC_CHAIN, 0, 0, 2);
      send_op(fca_pkg::FUNC_GET_NEXT, 0, 0, 0);
      write_size(7'd2);
      send_op(fca_pkg::FUNC_ALLOC_CHAIN, 0, 0, 3);
      send_op(fca_pkg::FUNC_ALLOC_CHAIN, 0, 0, 2);
      send_op(fca_pkg::FUNC_SET_NEXT, 1, 0, 0);
      send_op(fca_pkg::FUNC_FREE_CHAIN, 0, 0, 0);
   endtask

   task automatic random_op();
      int                pick;
      logic [6:0]        blk;
      logic [6:0]        nv;
      logic [6:0]        cnt;
      fca_pkg::func_type f;
      pick = $urandom_range(99);
      blk  = 7'($urandom_range(table_size + 1));
      if ($urandom_range(9) == 0)
         blk = 7'($urandom_range(127));
      else if ($urandom_range(9) == 0)
         blk = 7'($urandom_range(fca_pkg::FREE_MARK, fca_pkg::END_MARK));
      nv  = ($urandom_range(3) == 0) ? 7'($urandom_range(127))
                                     : 7'($urandom_range(table_size - 1));
      if ($urandom_range(4) == 0)
         nv = 7'($urandom_range(fca_pkg::FREE_MARK, fca_pkg::END_MARK));
      cnt = ($urandom_range(9) == 0) ? 7'($urandom_range(127))
                                     : 7'($urandom_range(6));
      if (pick < 18)      f = fca_pkg::FUNC_ALLOC;
      else if (pick < 38) f = fca_pkg::FUNC_ALLOC_CHAIN;
      else if (pick < 50) f = fca_pkg::FUNC_FREE_CHAIN;
      else if (pick < 61) f = fca_pkg::FUNC_SET_NEXT;
      else if (pick < 71) f = fca_pkg::FUNC_GET_NEXT;
      else if (pick < 80) f = fca_pkg::FUNC_IS_USED;
      else if (pick < 97) f = fca_pkg::FUNC_LIST_CHAIN;
      else                f = fca_pkg::FUNC_CLEAR;
      if ((f == fca_pkg::FUNC_FREE_CHAIN || f == fca_pkg::FUNC_LIST_CHAIN) &&
          chain_heads.size() != 0 && $urandom_range(3) != 0)
         blk = 7'(chain_heads[$urandom_range(chain_heads.size() - 1)]);
      send_op(f, blk, nv, cnt);
   endtask

   task automatic test_random_phase(int size, int idle, int stall, int items);
      write_size(7'(size));
      idle_pct  = idle;
      stall_pct = stall;
      for (int i = 0; i < items; i++) begin
         random_op();
         if (i == items / 2)
            drain();
      end
      drain();
   endtask

   initial begin
      table_size = fca_pkg::BLOCKS;
      wipe_table();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_ops();
      test_size_extremes();
      test_random_phase(fca_pkg::BLOCKS, 0, 0, 40);
      test_random_phase(8, 67, 0, 40);
      test_random_phase($urandom_range(1, fca_pkg::BLOCKS), 0, 67, 40);
      test_random_phase(16, 22, 22, 40);

      drain();
      repeat (SETTLE) @(negedge clock);
      $display("covered %0d operations and %0d response transactions", op_count, rsp_count);
      $display("table sizes 1, 2, 8, 16, 64 and one random size, four idle patterns");
      if (err_count == 0 && pending_rsp.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d errors, %0d responses missing", err_count, pending_rsp.size());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
